FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/pipc_pkg.sv
// Shared constants and types of the per-source packet counter.
`timescale 1ns / 1ps

package pipc_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ADDR_W = 32;
	localparam int COUNT_W = 32;

	localparam logic [ADDR_W-1:0] HASH_MULT = 32'h9E37_79B1;

	localparam logic [0:0] REQ_COUNT = 1'b0;
	localparam logic [0:0] REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic valid;
		logic [ADDR_W-1:0] key;
		logic [COUNT_W-1:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/per_source_ip_packet_counter.sv
// Top level of the per-source IPv4 packet counter: probe sequencer and result register.
`timescale 1ns / 1ps

// Each request hashes its address to a home slot and probes the entry memory
// linearly, one slot per cycle through its registered read port, until it hits
// the address, finds an empty slot or has probed all TABLE_ENTRIES slots. A request
// passes through the states S_HASH, S_PROBE and S_DONE, and the next request is
// taken only after S_DONE has handed the result to the output register, so requests
// do not overlap. After reset the block clears the valid bits of the memory and
// holds req_stall high until that pass ends.
// A finished result waits in the output register while the next request is taken.
module per_source_ip_packet_counter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        req_type,
	input  logic [pipc_pkg::ADDR_W-1:0]  ip_addr,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        found,
	output logic [pipc_pkg::COUNT_W-1:0] packet_count,
	output logic                        new_entry,
	output logic                        dropped
);
	import pipc_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   probe_q;
	logic [CNT_W-1:0]   probes_q;
	logic [CNT_W-1:0]   used_q;
	logic               type_q;
	logic [ADDR_W-1:0]  addr_q;

	logic               rfound_q;
	logic [COUNT_W-1:0] rcount_q;
	logic               rnew_q;
	logic               rdrop_q;

	logic               out_valid_q;
	logic               out_found_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_new_q;
	logic               out_drop_q;

	logic               accept;
	logic               out_free;
	logic               load_out;
	logic [IDX_W-1:0]   home_idx;
	logic [IDX_W-1:0]   next_idx;
	logic [ENTRY_W-1:0] rd_data;
	entry_t             rd_entry;
	entry_t             wr_entry;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               hit;
	logic               empty_slot;
	logic               last_probe;
	logic               is_count;
	logic               has_room;
	logic [COUNT_W-1:0] inc_count;

	function automatic logic [IDX_W-1:0] next_clear(input logic [IDX_W-1:0] idx);
		next_clear = idx + 1'b1;
	endfunction

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !res_stall;
	assign load_out = (state_q == S_DONE) && out_free;

	pipc_hash u_hash (
		.clk   (clk),
		.load  (accept),
		.addr  (ip_addr),
		.index (home_idx)
	);

	pipc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		rd_entry = entry_t'(rd_data);
		hit = rd_entry.valid && (rd_entry.key == addr_q);
		empty_slot = !rd_entry.valid;
		last_probe = (probes_q == CNT_W'(TABLE_ENTRIES));
		is_count = (type_q == REQ_COUNT);
		has_room = (used_q < CNT_W'(TABLE_ENTRIES));
		inc_count = (&rd_entry.count) ? rd_entry.count : rd_entry.count + 1'b1;
		next_idx = (probe_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : probe_q + 1'b1;
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = probe_q;
		wr_entry = '0;
		rd_en = 1'b0;
		rd_addr = home_idx;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
			end
			S_HASH: begin
				rd_en = 1'b1;
				rd_addr = home_idx;
			end
			S_PROBE: begin
				if (hit) begin
					wr_en = is_count;
					wr_entry = '{valid: 1'b1, key: addr_q, count: inc_count};
				end else if (empty_slot) begin
					wr_en = is_count && has_room;
					wr_entry = '{valid: 1'b1, key: addr_q, count: COUNT_W'(1)};
				end else if (!last_probe) begin
					rd_en = 1'b1;
					rd_addr = next_idx;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= next_clear(clr_q);
					if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (hit || empty_slot || last_probe) begin
						state_q <= S_DONE;
						if (!hit && empty_slot && is_count && has_room) begin
							used_q <= used_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req_type;
			addr_q <= ip_addr;
		end
		if (state_q == S_HASH) begin
			probe_q <= home_idx;
			probes_q <= CNT_W'(1);
		end else if (state_q == S_PROBE && !hit && !empty_slot && !last_probe) begin
			probe_q <= next_idx;
			probes_q <= probes_q + 1'b1;
		end
		if (state_q == S_PROBE) begin
			if (hit) begin
				rfound_q <= 1'b1;
				rcount_q <= is_count ? inc_count : rd_entry.count;
				rnew_q <= 1'b0;
				rdrop_q <= 1'b0;
			end else begin
				rfound_q <= 1'b0;
				rnew_q <= is_count && empty_slot && has_room;
				rdrop_q <= is_count && !(empty_slot && has_room);
				rcount_q <= (is_count && empty_slot && has_room) ? COUNT_W'(1) : '0;
			end
		end
		if (load_out) begin
			out_found_q <= rfound_q;
			out_count_q <= rcount_q;
			out_new_q <= rnew_q;
			out_drop_q <= rdrop_q;
		end
	end

	assign res_valid = out_valid_q;
	assign found = out_found_q;
	assign packet_count = out_count_q;
	assign new_entry = out_new_q;
	assign dropped = out_drop_q;

endmodule

FILE: rtl/pipc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module pipc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/pipc_hash.sv
// Multiplicative hash from a source address to a home slot of the table.
`timescale 1ns / 1ps

module pipc_hash (
	input  logic                       clk,
	input  logic                       load,
	input  logic [pipc_pkg::ADDR_W-1:0] addr,
	output logic [pipc_pkg::IDX_W-1:0] index
);
	import pipc_pkg::*;

	logic [ADDR_W-1:0] prod_q;
	logic [IDX_W-1:0]  top_bits;
	logic [CNT_W-1:0]  top_ext;
	logic [CNT_W-1:0]  reduced;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= addr * HASH_MULT;
		end
	end

	// The top bits stay below twice the table size, so one subtraction reduces them.
	always_comb begin
		top_bits = prod_q[ADDR_W-1 -: IDX_W];
		top_ext = CNT_W'(top_bits);
		if (top_ext >= CNT_W'(TABLE_ENTRIES)) begin
			reduced = top_ext - CNT_W'(TABLE_ENTRIES);
		end else begin
			reduced = top_ext;
		end
		index = reduced[IDX_W-1:0];
	end

endmodule

FILE: rtl/pipc_checker.sv
// Port-level assertions of the per-source packet counter and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pipc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        req_type,
	input logic [pipc_pkg::ADDR_W-1:0]  ip_addr,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic                        found,
	input logic [pipc_pkg::COUNT_W-1:0] packet_count,
	input logic                        new_entry,
	input logic                        dropped
);
	import pipc_pkg::*;

	logic req_xfer;
	logic res_one_flag;

	assign req_xfer = req_valid && !req_stall;
	assign res_one_flag = !(found && new_entry) && !(found && dropped) && !(new_entry && dropped);

	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid)
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_xfer, req_stall)
	`ASSERT_IMPLIES(a_one_flag, clk, arst_n, res_valid, res_one_flag)
	`ASSERT_IMPLIES(a_new_is_one, clk, arst_n, res_valid && new_entry, packet_count == COUNT_W'(1))
	`ASSERT_IMPLIES(a_absent_zero, clk, arst_n, res_valid && !found && !new_entry, packet_count == '0)

endmodule

bind per_source_ip_packet_counter pipc_checker u_pipc_checker (.*);
